// ----- sv/gb3_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and kernel weights for the 3x3 Gaussian blur block.
// No dependencies; every other file of the block imports this package.
package gb3_pkg;

	// Pixel and coordinate widths
	localparam int PIX_W      = 8;
	localparam int COORD_W    = 10;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;

	// Image size limits and reset value of the size registers
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int SIZE_RESET     = 1024;
	localparam int SIZE_MIN       = 3;

	// Kernel weights sum to 16, so the normalizing divide is a shift by 4
	localparam int KSHIFT = 4;
	localparam int SUM_W  = PIX_W + KSHIFT;
	localparam logic [2:0] KERNEL [3][3] = '{
		'{3'd1, 3'd2, 3'd1},
		'{3'd2, 3'd4, 3'd2},
		'{3'd1, 3'd2, 3'd1}
	};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 4'd0,
		REG_IMAGE_HEIGHT = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	// One column of the 3x3 window, oldest row on top
	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} wcol_t;

	// Line store word: row r-2 and row r-1 at one column
	typedef struct packed {
		pixel_t upper;
		pixel_t lower;
	} ls_word_t;

endpackage

// ----- sv/gb3_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input pixels, result pixels, config writes.
// Depends on gb3_pkg for field widths.
interface gb3_pix_if;
	import gb3_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface gb3_res_if;
	import gb3_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   out_red;
	logic [PIX_W-1:0]   out_green;
	logic [PIX_W-1:0]   out_blue;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;
	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_col, output out_row, input ready);
	modport sink   (input valid, input out_red, input out_green, input out_blue,
		input out_col, input out_row, output ready);
endinterface

interface gb3_cfg_if;
	import gb3_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/gb3_line_store.sv -----
`timescale 1ns / 1ps
// Two image rows held as one memory of 48-bit words, one word per column.
// Depends on gb3_pkg for ls_word_t. Read data is registered.
module gb3_line_store #(
	parameter int DEPTH = gb3_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output gb3_pkg::ls_word_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  gb3_pkg::ls_word_t wr_data
);
	import gb3_pkg::*;

	ls_word_t mem [DEPTH];
	ls_word_t rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/gb3_filter.sv -----
`timescale 1ns / 1ps
// 1-2-1 / 2-4-2 / 1-2-1 kernel over a 3x3 window, per color, divided by 16.
// Depends on gb3_pkg for pixel/window types and kernel weights.
module gb3_filter (
	input  gb3_pkg::wcol_t  left,
	input  gb3_pkg::wcol_t  center,
	input  gb3_pkg::wcol_t  right,
	output gb3_pkg::pixel_t blurred
);
	import gb3_pkg::*;

	pixel_t           px [3][3];
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;

	// weighted sums; max 16 * 255 fits in SUM_W bits
	always_comb begin
		px[0] = '{left.top, left.mid, left.bot};
		px[1] = '{center.top, center.mid, center.bot};
		px[2] = '{right.top, right.mid, right.bot};
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int k = 0; k < 3; k++) begin
			for (int y = 0; y < 3; y++) begin
				sum_r = sum_r + SUM_W'(px[k][y].red)   * SUM_W'(KERNEL[k][y]);
				sum_g = sum_g + SUM_W'(px[k][y].green) * SUM_W'(KERNEL[k][y]);
				sum_b = sum_b + SUM_W'(px[k][y].blue)  * SUM_W'(KERNEL[k][y]);
			end
		end
	end

	// truncating divide by 16
	assign blurred.red   = sum_r[SUM_W-1 -: PIX_W];
	assign blurred.green = sum_g[SUM_W-1 -: PIX_W];
	assign blurred.blue  = sum_b[SUM_W-1 -: PIX_W];

endmodule

// ----- sv/gaussian_blur_3x3_rgb_unit.sv -----
`timescale 1ns / 1ps
// 3x3 Gaussian blur on an RGB raster stream. Depends on gb3_pkg, the channel
// interfaces, gb3_line_store and gb3_filter.
//
// Pixels enter in raster order, one per clock when the result side keeps up.
// The pixel at column c, row r (both >= 1) yields the result pixel at
// (c-1, r-1); results on the first row or first column are zero, and the
// last row and column are never produced. An input pixel passes through
// stage 1, beside the registered line store read, and then the result
// register. Throughput is one item per cycle while the result side keeps
// up, set by the single read and single write per cycle of the line store.
// Writing image_width or image_height restarts the frame at pixel (0,0);
// sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT. Config writes are
// always taken and must only be issued while the block is idle.
module gaussian_blur_3x3_rgb_unit #(
	parameter int MAX_WIDTH  = gb3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gb3_pkg::MAX_HEIGHT_DEF
) (
	input logic      clk,
	input logic      arst_n,
	gb3_cfg_if.sink  cfg,
	gb3_pix_if.sink  pix_in,
	gb3_res_if.source res_out
);
	import gb3_pkg::*;

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int HW    = $clog2(MAX_HEIGHT);
	localparam int XW    = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
	localparam int XH    = (HW + 1 > CFG_DATA_W) ? HW + 1 : CFG_DATA_W;
	localparam int W_RST = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
	localparam int H_RST = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

	logic          cfg_fire;
	logic          wr_w;
	logic          wr_h;
	logic [XW-1:0] w_ext;
	logic [XW-1:0] w_clamp;
	logic [XH-1:0] h_ext;
	logic [XH-1:0] h_clamp;
	logic [AW-1:0] wm1_q;
	logic [HW-1:0] hm1_q;

	logic          in_fire;
	logic          in_ready;
	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;

	logic          s1_valid_s1;
	pixel_t        pix_s1;
	logic [AW-1:0] col_s1;
	logic [HW-1:0] row_s1;
	logic          s1_move;
	logic          s1_emit;
	logic          s1_interior;
	logic [AW-1:0] s1_oc;
	logic [HW-1:0] s1_or;

	ls_word_t      ls_rd;
	ls_word_t      ls_wr;
	wcol_t         cur_col;
	wcol_t         win0_q;
	wcol_t         win1_q;
	pixel_t        blur_pix;

	logic               out_valid_q;
	pixel_t             out_pix_q;
	logic [COORD_W-1:0] out_col_q;
	logic [COORD_W-1:0] out_row_q;

	// config decode and size clamping
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_comb begin
		wr_w = 1'b0;
		wr_h = 1'b0;
		unique case (cfg.index)
			REG_IMAGE_WIDTH:  wr_w = cfg_fire;
			REG_IMAGE_HEIGHT: wr_h = cfg_fire;
			default: ;
		endcase
	end

	always_comb begin
		w_ext = XW'(cfg.data);
		h_ext = XH'(cfg.data);
		if (w_ext < XW'(SIZE_MIN)) begin
			w_clamp = XW'(SIZE_MIN);
		end else if (w_ext > XW'(MAX_WIDTH)) begin
			w_clamp = XW'(MAX_WIDTH);
		end else begin
			w_clamp = w_ext;
		end
		if (h_ext < XH'(SIZE_MIN)) begin
			h_clamp = XH'(SIZE_MIN);
		end else if (h_ext > XH'(MAX_HEIGHT)) begin
			h_clamp = XH'(MAX_HEIGHT);
		end else begin
			h_clamp = h_ext;
		end
	end

	// size registers hold (clamped size - 1)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= AW'(W_RST - 1);
			hm1_q <= HW'(H_RST - 1);
		end else begin
			if (wr_w) begin
				wm1_q <= AW'(w_clamp - XW'(1));
			end
			if (wr_h) begin
				hm1_q <= HW'(h_clamp - XH'(1));
			end
		end
	end

	// position of the next input pixel
	assign in_ready     = !s1_valid_s1 || s1_move;
	assign pix_in.ready = in_ready;
	assign in_fire      = pix_in.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (wr_w || wr_h) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_q == wm1_q) begin
				col_q <= '0;
				row_q <= (row_q == hm1_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1: input pixel, aligned with the line store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1 <= '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	assign s1_move     = s1_valid_s1 && (!out_valid_q || res_out.ready);
	assign s1_emit     = (col_s1 != '0) && (row_s1 != '0);
	assign s1_interior = (col_s1 > AW'(1)) && (row_s1 > HW'(1));
	assign s1_oc       = col_s1 - 1'b1;
	assign s1_or       = row_s1 - 1'b1;

	// line stores: read on accept, shift rows down when the item leaves stage 1
	assign ls_wr = '{upper: ls_rd.lower, lower: pix_s1};

	gb3_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (col_q),
		.rd_data (ls_rd),
		.wr_en   (s1_move),
		.wr_addr (col_s1),
		.wr_data (ls_wr)
	);

	// 3x3 window: two stored columns plus the current one
	assign cur_col = '{top: ls_rd.upper, mid: ls_rd.lower, bot: pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (s1_move) begin
			win0_q <= win1_q;
			win1_q <= cur_col;
		end
	end

	gb3_filter u_filter (
		.left    (win0_q),
		.center  (win1_q),
		.right   (cur_col),
		.blurred (blur_pix)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= s1_emit;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_emit) begin
			out_pix_q <= s1_interior ? blur_pix : '0;
			out_col_q <= COORD_W'(s1_oc);
			out_row_q <= COORD_W'(s1_or);
		end
	end

	assign res_out.valid     = out_valid_q;
	assign res_out.out_red   = out_pix_q.red;
	assign res_out.out_green = out_pix_q.green;
	assign res_out.out_blue  = out_pix_q.blue;
	assign res_out.out_col   = out_col_q;
	assign res_out.out_row   = out_row_q;

endmodule

// ----- sv/gb3_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for gaussian_blur_3x3_rgb_unit, bound to the top level.
// Depends on gb3_pkg for field widths.
module gb3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [gb3_pkg::PIX_W-1:0]   out_red,
	input logic [gb3_pkg::PIX_W-1:0]   out_green,
	input logic [gb3_pkg::PIX_W-1:0]   out_blue,
	input logic [gb3_pkg::COORD_W-1:0] out_col,
	input logic [gb3_pkg::COORD_W-1:0] out_row
);
	import gb3_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({out_red, out_green, out_blue, out_col, out_row}))
		else $error("result changed while stalled");

	// first row and first column come out as zero
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_col == '0 || out_row == '0) |->
			out_red == '0 && out_green == '0 && out_blue == '0)
		else $error("nonzero result on border");

	// a fresh result follows an accepted item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching input");

	// the input side only stalls behind a stalled result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while result side free");

endmodule

bind gaussian_blur_3x3_rgb_unit gb3_checker u_gb3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_red   (res_out.out_red),
	.out_green (res_out.out_green),
	.out_blue  (res_out.out_blue),
	.out_col   (res_out.out_col),
	.out_row   (res_out.out_row)
);

// ----- verif/gaussian_blur_3x3_rgb_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for gaussian_blur_3x3_rgb_unit: random RGB raster frames
// of many sizes, an in-bench blur predictor and a scoreboard on the result channel.
// Depends on gb3_pkg, the gb3 channel interfaces and the block itself.
module gaussian_blur_3x3_rgb_unit_tb;
	import gb3_pkg::*;

	localparam int MAX_W      = MAX_WIDTH_DEF;
	localparam int MAX_H      = MAX_HEIGHT_DEF;
	localparam int SETTLE_CYC = 8;
	localparam int STALL_LIM  = 4000;
	localparam int RAND_ITEMS = 1400;
	localparam int HOLD_CYC   = 150;
	localparam int HOLD_AT    = 1000;
	localparam int TAP [3]    = '{1, 2, 1};
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hF;

	typedef struct packed {
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} blur_res_t;

	logic clk = 1'b0;
	logic arst_n;

	gb3_cfg_if cfg ();
	gb3_pix_if pix_in ();
	gb3_res_if res_out ();

	gaussian_blur_3x3_rgb_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pix_in  (pix_in),
		.res_out (res_out)
	);

	always #5 clk = ~clk;

	// Predictor state: sizes, line stores, window and raster position
	logic [CFG_DATA_W-1:0] img_w_reg;
	logic [CFG_DATA_W-1:0] img_h_reg;
	pixel_t ls_upper [MAX_W];
	pixel_t ls_lower [MAX_W];
	pixel_t win_old [3];
	pixel_t win_new [3];
	int col_cnt;
	int row_cnt;

	pixel_t    pend_q [$];
	blur_res_t blur_q [$];

	int pix_acc;
	int res_acc;
	int bad_cnt;
	int send_idle;
	int recv_idle;
	int hold_left;
	bit hold_done;
	int quiet_cyc;
	pixel_t cur_px;

	function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v, int hi);
		if (v < SIZE_MIN)
			return SIZE_MIN;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	// Blur one accepted pixel: queue the result it emits, then advance the state
	function automatic void blur_predict(pixel_t px);
		int w, h, c, r, idx, k, y, wt, s_r, s_g, s_b;
		pixel_t win3 [3][3];
		blur_res_t res;
		w = clamp_dim(img_w_reg, MAX_W);
		h = clamp_dim(img_h_reg, MAX_H);
		c = col_cnt;
		r = row_cnt;
		idx = (c < MAX_W) ? c : MAX_W - 1;
		win3[0] = win_old;
		win3[1] = win_new;
		win3[2][0] = ls_upper[idx];
		win3[2][1] = ls_lower[idx];
		win3[2][2] = px;
		if (c >= 1 && r >= 1) begin
			res = '0;
			res.col = COORD_W'(c - 1);
			res.row = COORD_W'(r - 1);
			// interior only; first row and column stay zero
			if (c >= 2 && r >= 2) begin
				s_r = 0;
				s_g = 0;
				s_b = 0;
				for (k = 0; k < 3; k++)
					for (y = 0; y < 3; y++) begin
						wt = TAP[k] * TAP[y];
						s_r += wt * win3[k][y].red;
						s_g += wt * win3[k][y].green;
						s_b += wt * win3[k][y].blue;
					end
				res.red = PIX_W'(s_r >> KSHIFT);
				res.green = PIX_W'(s_g >> KSHIFT);
				res.blue = PIX_W'(s_b >> KSHIFT);
			end
			blur_q.push_back(res);
		end
		ls_upper[idx] = win3[2][1];
		ls_lower[idx] = px;
		win_old = win_new;
		win_new = win3[2];
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_cnt = c;
		row_cnt = r;
	endfunction

	// Idle mix by progress: sender-light, then receiver-light, then none
	always_comb begin
		if (pix_acc < 470) begin
			send_idle = 29;
			recv_idle = 85;
		end else if (pix_acc < 940) begin
			send_idle = 85;
			recv_idle = 29;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	end

	// Pixel driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_in.valid && pix_in.ready) begin
				blur_predict(cur_px);
				pix_acc <= pix_acc + 1;
			end
			if (!pix_in.valid || pix_in.ready) begin
				if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_px = pend_q.pop_front();
					pix_in.valid <= 1'b1;
					pix_in.red <= cur_px.red;
					pix_in.green <= cur_px.green;
					pix_in.blue <= cur_px.blue;
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and scoreboard, plus receiver backpressure
	always @(posedge clk) begin : mon
		blur_res_t got, want;
		if (arst_n) begin
			if (res_out.valid && res_out.ready) begin
				got.red = res_out.out_red;
				got.green = res_out.out_green;
				got.blue = res_out.out_blue;
				got.col = res_out.out_col;
				got.row = res_out.out_row;
				res_acc <= res_acc + 1;
				if (blur_q.size() == 0) begin
					if (bad_cnt < 10)
						$display("%0t: unexpected result rgb=%h/%h/%h at (%0d,%0d)", $realtime,
							got.red, got.green, got.blue, got.col, got.row);
					bad_cnt++;
				end else begin
					want = blur_q.pop_front();
					if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue || got.col !== want.col
						|| got.row !== want.row) begin
						if (bad_cnt < 10)
							$display("%0t: mismatch exp rgb=%h/%h/%h (%0d,%0d) got rgb=%h/%h/%h (%0d,%0d)",
								$realtime, want.red, want.green, want.blue, want.col, want.row,
								got.red, got.green, got.blue, got.col, got.row);
						bad_cnt++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (!hold_done && pix_acc >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYC;
				res_out.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_out.ready <= 1'b0;
			end else begin
				res_out.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog on cycles with no item moving on any channel
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready)
			|| (cfg.valid && cfg.ready))
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= STALL_LIM) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Wait until the block has drained
	task automatic settle();
		while (pend_q.size() != 0 || pix_in.valid || blur_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		// size writes restart the frame
		case (idx)
			REG_IMAGE_WIDTH: img_w_reg = val;
			REG_IMAGE_HEIGHT: img_h_reg = val;
			default: return;
		endcase
		col_cnt = 0;
		row_cnt = 0;
	endtask

	task automatic push_random(int n);
		repeat (n) pend_q.push_back(pixel_t'($urandom));
	endtask

	// Stimulus
	initial begin
		pixel_t dir_px [13];
		int pushed, n, pick;
		bit big_done;
		logic [CFG_DATA_W-1:0] w, h;
		dir_px = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00,
			24'h805A01};
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pix_in.valid = 1'b0;
		pix_in.red = '0;
		pix_in.green = '0;
		pix_in.blue = '0;
		res_out.ready = 1'b0;
		img_w_reg = CFG_DATA_W'(SIZE_RESET);
		img_h_reg = CFG_DATA_W'(SIZE_RESET);
		foreach (ls_upper[i]) begin
			ls_upper[i] = '0;
			ls_lower[i] = '0;
		end
		win_old = '{default: '0};
		win_new = '{default: '0};
		col_cnt = 0;
		row_cnt = 0;
		pix_acc = 0;
		res_acc = 0;
		bad_cnt = 0;
		hold_left = 0;
		hold_done = 1'b0;
		quiet_cyc = 0;
		cur_px = '0;
		big_done = 1'b0;
		pushed = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Undersized 3x3 frame: saturated full-scale pixels, then wrap into the next frame
		cfg_write(REG_IMAGE_WIDTH, '0);
		cfg_write(REG_IMAGE_HEIGHT, 11'd1);
		foreach (dir_px[i])
			pend_q.push_back(dir_px[i]);
		settle();

		// Width 2 clamps to 3, oversized height clamps to max
		cfg_write(REG_IMAGE_WIDTH, 11'd2);
		cfg_write(REG_IMAGE_HEIGHT, '1);
		for (int i = 0; i < 8; i++)
			pend_q.push_back((i % 2) ? 24'h000000 : 24'hFFFFFF);
		settle();
		// write to an unused index mid-frame: position must carry on
		cfg_write(REG_SPARE, '1);
		for (int i = 0; i < 4; i++)
			pend_q.push_back((i % 2) ? 24'hFFFFFF : 24'h010203);
		settle();

		// Random frames; one oversized-width frame, the rest mostly small
		while (pushed < RAND_ITEMS) begin
			if (!big_done && pushed >= 200) begin
				big_done = 1'b1;
				n = MAX_W + 6;
				w = '1;
				h = 11'd3;
			end else begin
				pick = $urandom_range(99);
				n = $urandom_range(20, 60);
				if (pick < 70) begin
					w = CFG_DATA_W'($urandom_range(3, 16));
					h = CFG_DATA_W'($urandom_range(3, 8));
				end else if (pick < 85) begin
					w = CFG_DATA_W'($urandom_range(0, 2));
					h = CFG_DATA_W'($urandom_range(0, 2));
				end else begin
					w = CFG_DATA_W'($urandom_range(0, 2047));
					h = CFG_DATA_W'($urandom_range(0, 2047));
				end
			end
			cfg_write(REG_IMAGE_WIDTH, w);
			cfg_write(REG_IMAGE_HEIGHT, h);
			if ($urandom_range(1)) begin
				push_random(n / 2);
				// sender pause until the block has drained
				settle();
				push_random(n - n / 2);
			end else begin
				push_random(n);
			end
			pushed += n;
			settle();
		end

		if (blur_q.size() != 0)
			bad_cnt++;
		if (bad_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
